FILE: hw/rtl/gim_pkg.sv
// shared types, constants and the sequencer microprogram for the glucose-insulin step block
// no dependencies; imported by glucose_insulin_model_step and its bench
`timescale 1ns / 1ps
`default_nettype none

package gim_pkg;

  localparam int NComp    = 10;
  localparam int CompW    = 40;
  localparam int WideW    = 64;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int PcW      = 7;

  typedef logic [CompW-1:0] comp_t;
  typedef logic [WideW-1:0] word_t;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BODY_WEIGHT      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GLUCOSE_VOLUME   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SENS_TRANSPORT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SENS_DISPOSAL    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SENS_PRODUCTION  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BASAL_PRODUCTION = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BRAIN_UPTAKE     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STEP_MINUTES     = 3'd7;

  localparam logic [15:0] RST_BODY_WEIGHT      = 16'd19200;
  localparam logic [15:0] RST_GLUCOSE_VOLUME   = 16'd10486;
  localparam logic [23:0] RST_SENS_TRANSPORT   = 24'd85899;
  localparam logic [23:0] RST_SENS_DISPOSAL    = 24'd13757;
  localparam logic [23:0] RST_SENS_PRODUCTION  = 24'd872415;
  localparam logic [23:0] RST_BASAL_PRODUCTION = 24'd270113;
  localparam logic [23:0] RST_BRAIN_UPTAKE     = 24'd162739;
  localparam logic [15:0] RST_STEP_MINUTES     = 16'd256;

  // compartment indexes
  localparam logic [3:0] CI_Q1 = 4'd0;
  localparam logic [3:0] CI_Q2 = 4'd1;
  localparam logic [3:0] CI_S1 = 4'd2;
  localparam logic [3:0] CI_S2 = 4'd3;
  localparam logic [3:0] CI_I  = 4'd4;
  localparam logic [3:0] CI_X1 = 4'd5;
  localparam logic [3:0] CI_X2 = 4'd6;
  localparam logic [3:0] CI_X3 = 4'd7;
  localparam logic [3:0] CI_D1 = 4'd8;
  localparam logic [3:0] CI_D2 = 4'd9;

  // fixed model constants, Q40.24 unless noted
  localparam word_t C_K12   = 64'd1107296;
  localparam word_t C_KA1   = 64'd100663;
  localparam word_t C_KA2   = 64'd1006633;
  localparam word_t C_KA3   = 64'd503316;
  localparam word_t C_KE    = 64'd2315256;
  localparam word_t C_AG    = 64'd13421773;
  localparam word_t C_RTI   = 64'd305040;
  localparam word_t C_RTG   = 64'd419430;
  localparam word_t C_R45   = 64'd3728270;
  localparam word_t C_G45   = 64'd75497472;
  localparam word_t C_G9    = 64'd150994944;
  localparam word_t C_FR    = 64'd50332;
  localparam word_t C_CARB  = 64'd93124;
  localparam word_t C_IIR   = 64'd279620;
  localparam word_t C_IGAIN = 64'd2541964;
  localparam word_t C_MGDL  = 64'd1180697;
  localparam word_t C_ONE24 = 64'd16777216;

  typedef struct packed {
    logic        kind;
    logic [15:0] carb_rate;
    logic [15:0] infusion_rate;
    logic [3:0]  compartment_index;
    logic [39:0] compartment_value;
  } in_item_t;

  typedef struct packed {
    logic [23:0] glucose_mg_dl;
    logic [23:0] plasma_insulin;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_MUL, ST_DIV, ST_WB, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_DIV, OP_UPD, OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    SRC_ZERO, SRC_NZVG, SRC_NZBW, SRC_BW, SRC_DVOL, SRC_Q1SH, SRC_G, SRC_RATIO,
    SRC_TMP, SRC_POS, SRC_NEG, SRC_XFER, SRC_UG, SRC_SHR, SRC_BU, SRC_BP,
    SRC_ST, SRC_SD, SRC_SP, SRC_STEP, SRC_Q1, SRC_Q2, SRC_S1, SRC_S2,
    SRC_INS, SRC_X1, SRC_X2, SRC_X3, SRC_D1, SRC_D2, SRC_X3INV, SRC_GEXC,
    SRC_K12X2, SRC_CARB, SRC_IIR, SRC_K12, SRC_KA1, SRC_KA2, SRC_KA3, SRC_KE,
    SRC_AG, SRC_RTI, SRC_RTG, SRC_R45, SRC_FR, SRC_CARBK, SRC_IIRK, SRC_IGAIN,
    SRC_MGDL
  } src_t;

  typedef enum logic [3:0] {
    DST_DVOL, DST_G, DST_RATIO, DST_TMP, DST_POS, DST_NEG, DST_XFER, DST_UG,
    DST_SHR
  } dst_t;

  typedef enum logic [2:0] {
    SH0, SH8, SH16, SH24, SH32
  } shift_t;

  typedef struct packed {
    op_t        op;
    src_t       a;
    src_t       b;
    shift_t     sh;
    dst_t       dst;
    logic [3:0] ci;
  } uop_t;

  localparam logic [PcW-1:0] PC_TICK = 7'd0;
  localparam logic [PcW-1:0] PC_OUT  = 7'd70;

  function automatic uop_t u_make(op_t op, dst_t d, src_t a, src_t b, shift_t s,
                                  logic [3:0] ci);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.sh  = s;
    u.dst = d;
    u.ci  = ci;
    return u;
  endfunction

  function automatic uop_t u_mul(dst_t d, src_t a, src_t b, shift_t s);
    return u_make(OP_MUL, d, a, b, s, CI_Q1);
  endfunction

  function automatic uop_t u_div(dst_t d, src_t a, src_t b, shift_t s);
    return u_make(OP_DIV, d, a, b, s, CI_Q1);
  endfunction

  function automatic uop_t u_add(dst_t d, src_t a, src_t b);
    return u_make(OP_ADD, d, a, b, SH0, CI_Q1);
  endfunction

  function automatic uop_t u_upd(logic [3:0] ci);
    return u_make(OP_UPD, DST_POS, SRC_POS, SRC_NEG, SH0, ci);
  endfunction

  function automatic uop_t u_out();
    return u_make(OP_OUT, DST_TMP, SRC_TMP, SRC_ZERO, SH0, CI_Q1);
  endfunction

  // compartments are updated in an order that never reads one already advanced
  function automatic uop_t ucode(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // glucose and the shared fluxes, then Q1
      7'd0:  u = u_mul(DST_DVOL, SRC_NZVG, SRC_NZBW, SH0);
      7'd1:  u = u_div(DST_G, SRC_Q1SH, SRC_DVOL, SH0);
      7'd2:  u = u_mul(DST_TMP, SRC_BU, SRC_BW, SH8);
      7'd3:  u = u_mul(DST_RATIO, SRC_G, SRC_R45, SH24);
      7'd4:  u = u_mul(DST_NEG, SRC_TMP, SRC_RATIO, SH24);
      7'd5:  u = u_mul(DST_XFER, SRC_X1, SRC_Q1, SH24);
      7'd6:  u = u_add(DST_NEG, SRC_NEG, SRC_XFER);
      7'd7:  u = u_mul(DST_TMP, SRC_GEXC, SRC_FR, SH24);
      7'd8:  u = u_add(DST_NEG, SRC_NEG, SRC_TMP);
      7'd9:  u = u_mul(DST_UG, SRC_D2, SRC_RTG, SH24);
      7'd10: u = u_mul(DST_TMP, SRC_BP, SRC_BW, SH8);
      7'd11: u = u_mul(DST_POS, SRC_TMP, SRC_X3INV, SH24);
      7'd12: u = u_add(DST_POS, SRC_POS, SRC_UG);
      7'd13: u = u_mul(DST_TMP, SRC_K12, SRC_Q2, SH24);
      7'd14: u = u_add(DST_POS, SRC_POS, SRC_TMP);
      7'd15: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd16: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd17: u = u_upd(CI_Q1);
      // Q2
      7'd18: u = u_add(DST_POS, SRC_XFER, SRC_ZERO);
      7'd19: u = u_mul(DST_NEG, SRC_K12X2, SRC_Q2, SH24);
      7'd20: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd21: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd22: u = u_upd(CI_Q2);
      // D2
      7'd23: u = u_mul(DST_SHR, SRC_D1, SRC_RTG, SH24);
      7'd24: u = u_add(DST_POS, SRC_SHR, SRC_ZERO);
      7'd25: u = u_add(DST_NEG, SRC_UG, SRC_ZERO);
      7'd26: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd27: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd28: u = u_upd(CI_D2);
      // D1
      7'd29: u = u_mul(DST_TMP, SRC_CARB, SRC_CARBK, SH0);
      7'd30: u = u_mul(DST_POS, SRC_TMP, SRC_AG, SH24);
      7'd31: u = u_add(DST_NEG, SRC_SHR, SRC_ZERO);
      7'd32: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd33: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd34: u = u_upd(CI_D1);
      // x1
      7'd35: u = u_mul(DST_TMP, SRC_ST, SRC_INS, SH24);
      7'd36: u = u_mul(DST_POS, SRC_KA1, SRC_TMP, SH24);
      7'd37: u = u_mul(DST_NEG, SRC_KA1, SRC_X1, SH24);
      7'd38: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd39: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd40: u = u_upd(CI_X1);
      // x2
      7'd41: u = u_mul(DST_TMP, SRC_SD, SRC_INS, SH24);
      7'd42: u = u_mul(DST_POS, SRC_KA2, SRC_TMP, SH24);
      7'd43: u = u_mul(DST_NEG, SRC_KA2, SRC_X2, SH24);
      7'd44: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd45: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd46: u = u_upd(CI_X2);
      // x3
      7'd47: u = u_mul(DST_TMP, SRC_SP, SRC_INS, SH24);
      7'd48: u = u_mul(DST_POS, SRC_KA3, SRC_TMP, SH24);
      7'd49: u = u_mul(DST_NEG, SRC_KA3, SRC_X3, SH24);
      7'd50: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd51: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd52: u = u_upd(CI_X3);
      // plasma insulin
      7'd53: u = u_mul(DST_TMP, SRC_S2, SRC_IGAIN, SH0);
      7'd54: u = u_div(DST_POS, SRC_TMP, SRC_NZBW, SH16);
      7'd55: u = u_mul(DST_NEG, SRC_KE, SRC_INS, SH24);
      7'd56: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd57: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd58: u = u_upd(CI_I);
      // S2
      7'd59: u = u_mul(DST_SHR, SRC_S1, SRC_RTI, SH24);
      7'd60: u = u_add(DST_POS, SRC_SHR, SRC_ZERO);
      7'd61: u = u_mul(DST_NEG, SRC_S2, SRC_RTI, SH24);
      7'd62: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd63: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd64: u = u_upd(CI_S2);
      // S1
      7'd65: u = u_mul(DST_POS, SRC_IIR, SRC_IIRK, SH0);
      7'd66: u = u_add(DST_NEG, SRC_SHR, SRC_ZERO);
      7'd67: u = u_mul(DST_POS, SRC_POS, SRC_STEP, SH8);
      7'd68: u = u_mul(DST_NEG, SRC_NEG, SRC_STEP, SH8);
      7'd69: u = u_upd(CI_S1);
      // result from the new state
      7'd70: u = u_mul(DST_DVOL, SRC_NZVG, SRC_NZBW, SH0);
      7'd71: u = u_div(DST_G, SRC_Q1SH, SRC_DVOL, SH0);
      7'd72: u = u_mul(DST_TMP, SRC_G, SRC_MGDL, SH32);
      default: u = u_out();
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/glucose_insulin_model_step.sv
// glucose-insulin model: one forward-euler step or one compartment load per item
// depends on gim_pkg (types, constants, microprogram)
`timescale 1ns / 1ps
`default_nettype none

// A tick item advances all ten compartments by one time step and a load item writes one
// compartment (none for an index of ten or more); each returns glucose in mg/dl and plasma
// insulin from the new state. Multiplies use one shared 64x64 multiplier, worked 16 bits of
// one operand a cycle, divides one restoring divider that makes a quotient bit a cycle, each
// with issue and write-back; adds and updates use a separate adder; a microprogrammed
// sequencer runs it all. A tick runs 50 multiplies, 3 divides and 20 adds and updates, a
// load the 2 multiplies and the divide of the result. One item is worked at a time:
// in_ready is high only while idle, and the result is held on the output until taken.
module glucose_insulin_model_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gim_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gim_pkg::out_item_t            out_item,
  input  logic                          cfg_write,
  input  logic [gim_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gim_pkg::CfgDataW-1:0]  cfg_data
);
  import gim_pkg::*;

  localparam int DigitW    = 16;
  localparam int MulDigits = WideW / DigitW;
  localparam int MulCntW   = $clog2(MulDigits);
  localparam int DivCntW   = $clog2(WideW);

  // configuration
  logic [15:0] body_weight, glucose_volume, step_minutes;
  logic [23:0] sens_transport, sens_disposal, sens_production;
  logic [23:0] basal_production, brain_uptake;

  // state and working registers
  comp_t       comp [NComp];
  logic [15:0] carb, iir;
  logic [31:0] dvol;
  word_t       g, tmp, pos, neg;
  logic [24:0] ratio;
  logic [55:0] xfer;
  logic [34:0] ug, shr;

  state_t         state, state_next;
  logic [PcW-1:0] pc;
  uop_t           uop;
  logic           accept;

  // multiplier and divider
  word_t                mul_a, mul_b;
  logic [127:0]         acc;
  logic [MulCntW-1:0]   mul_cnt;
  logic [79:0]          pp;
  word_t                div_num, div_quo;
  logic [31:0]          div_den, div_rem;
  logic [32:0]          div_trial;
  logic                 div_ge;
  logic [DivCntW-1:0]   div_cnt;

  word_t        op_a, op_b, mul_res, div_res, add_res, wb_val;
  logic [127:0] prod_sh;
  logic [64:0]  add_sum;
  logic         wb_en;
  comp_t        upd_old, upd_val;
  word_t        gain, loss;
  logic [64:0]  upd_sum;
  logic [15:0]  nz_vg, nz_bw;
  logic [40:0]  x3c;

  always_comb begin
    uop    = ucode(pc);
    accept = in_valid && in_ready;
    nz_vg  = (glucose_volume == '0) ? 16'd1 : glucose_volume;
    nz_bw  = (body_weight == '0) ? 16'd1 : body_weight;
    x3c    = (64'(comp[CI_X3]) > C_ONE24) ? C_ONE24[40:0] : 41'(comp[CI_X3]);
  end

  function automatic word_t src_value(src_t s);
    word_t v;
    case (s)
      SRC_ZERO:  v = '0;
      SRC_NZVG:  v = 64'(nz_vg);
      SRC_NZBW:  v = 64'(nz_bw);
      SRC_BW:    v = 64'(body_weight);
      SRC_DVOL:  v = 64'(dvol);
      SRC_Q1SH:  v = {comp[CI_Q1], 24'd0};
      SRC_G:     v = g;
      SRC_RATIO: v = 64'(ratio);
      SRC_TMP:   v = tmp;
      SRC_POS:   v = pos;
      SRC_NEG:   v = neg;
      SRC_XFER:  v = 64'(xfer);
      SRC_UG:    v = 64'(ug);
      SRC_SHR:   v = 64'(shr);
      SRC_BU:    v = 64'(brain_uptake);
      SRC_BP:    v = 64'(basal_production);
      SRC_ST:    v = 64'(sens_transport);
      SRC_SD:    v = 64'(sens_disposal);
      SRC_SP:    v = 64'(sens_production);
      SRC_STEP:  v = 64'(step_minutes);
      SRC_Q1:    v = 64'(comp[CI_Q1]);
      SRC_Q2:    v = 64'(comp[CI_Q2]);
      SRC_S1:    v = 64'(comp[CI_S1]);
      SRC_S2:    v = 64'(comp[CI_S2]);
      SRC_INS:   v = 64'(comp[CI_I]);
      SRC_X1:    v = 64'(comp[CI_X1]);
      SRC_X2:    v = 64'(comp[CI_X2]);
      SRC_X3:    v = 64'(comp[CI_X3]);
      SRC_D1:    v = 64'(comp[CI_D1]);
      SRC_D2:    v = 64'(comp[CI_D2]);
      SRC_X3INV: v = C_ONE24 - 64'(x3c);
      SRC_GEXC:  v = (g > C_G9) ? g - C_G9 : '0;
      SRC_K12X2: v = C_K12 + 64'(comp[CI_X2]);
      SRC_CARB:  v = 64'(carb);
      SRC_IIR:   v = 64'(iir);
      SRC_K12:   v = C_K12;
      SRC_KA1:   v = C_KA1;
      SRC_KA2:   v = C_KA2;
      SRC_KA3:   v = C_KA3;
      SRC_KE:    v = C_KE;
      SRC_AG:    v = C_AG;
      SRC_RTI:   v = C_RTI;
      SRC_RTG:   v = C_RTG;
      SRC_R45:   v = C_R45;
      SRC_FR:    v = C_FR;
      SRC_CARBK: v = C_CARB;
      SRC_IIRK:  v = C_IIR;
      SRC_IGAIN: v = C_IGAIN;
      SRC_MGDL:  v = C_MGDL;
      default:   v = '0;
    endcase
    return v;
  endfunction

  // datapath
  always_comb begin
    op_a = src_value(uop.a);
    op_b = src_value(uop.b);

    pp = 80'(mul_a) * 80'(mul_b[WideW-1 -: DigitW]);
    case (uop.sh)
      SH0:     prod_sh = acc;
      SH8:     prod_sh = acc >> 8;
      SH16:    prod_sh = acc >> 16;
      SH24:    prod_sh = acc >> 24;
      SH32:    prod_sh = acc >> 32;
      default: prod_sh = acc;
    endcase
    mul_res = (|prod_sh[127:64]) ? '1 : prod_sh[63:0];
    div_res = (uop.sh == SH16) ? (div_quo >> 16) : div_quo;

    div_trial = {div_rem, div_num[WideW-1]};
    div_ge    = div_trial >= {1'b0, div_den};

    add_sum = {1'b0, op_a} + {1'b0, op_b};
    add_res = add_sum[64] ? '1 : add_sum[63:0];

    // advance: old plus the stepped rate difference, clamped to the compartment range
    upd_old = comp[uop.ci];
    gain    = pos - neg;
    loss    = neg - pos;
    upd_sum = {1'b0, gain} + 65'(upd_old);
    if (pos >= neg) begin
      upd_val = (upd_sum > 65'({CompW{1'b1}})) ? '1 : upd_sum[CompW-1:0];
    end else begin
      upd_val = (64'(upd_old) > loss) ? upd_old - loss[CompW-1:0] : '0;
    end

    wb_en  = (state == ST_WB) || (state == ST_ISSUE && uop.op == OP_ADD);
    wb_val = (state == ST_WB) ? ((uop.op == OP_DIV) ? div_res : mul_res) : add_res;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE);
    out_valid  = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (uop.op)
          OP_MUL:  state_next = ST_MUL;
          OP_DIV:  state_next = ST_DIV;
          OP_OUT:  state_next = ST_OUT;
          default: state_next = ST_ISSUE;
        endcase
      end
      ST_MUL: begin
        if (mul_cnt == MulCntW'(MulDigits - 1)) begin
          state_next = ST_WB;
        end
      end
      ST_DIV: begin
        if (div_cnt == DivCntW'(WideW - 1)) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        state_next = ST_ISSUE;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_TICK;
    end else if (accept) begin
      pc <= in_item.kind ? PC_OUT : PC_TICK;
    end else if (state == ST_WB ||
                 (state == ST_ISSUE && (uop.op == OP_ADD || uop.op == OP_UPD))) begin
      pc <= pc + 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      body_weight      <= RST_BODY_WEIGHT;
      glucose_volume   <= RST_GLUCOSE_VOLUME;
      sens_transport   <= RST_SENS_TRANSPORT;
      sens_disposal    <= RST_SENS_DISPOSAL;
      sens_production  <= RST_SENS_PRODUCTION;
      basal_production <= RST_BASAL_PRODUCTION;
      brain_uptake     <= RST_BRAIN_UPTAKE;
      step_minutes     <= RST_STEP_MINUTES;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BODY_WEIGHT:      body_weight      <= cfg_data[15:0];
        REG_GLUCOSE_VOLUME:   glucose_volume   <= cfg_data[15:0];
        REG_SENS_TRANSPORT:   sens_transport   <= cfg_data;
        REG_SENS_DISPOSAL:    sens_disposal    <= cfg_data;
        REG_SENS_PRODUCTION:  sens_production  <= cfg_data;
        REG_BASAL_PRODUCTION: basal_production <= cfg_data;
        REG_BRAIN_UPTAKE:     brain_uptake     <= cfg_data;
        REG_STEP_MINUTES:     step_minutes     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // compartments
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NComp; i++) begin
        comp[i] <= '0;
      end
    end else if (accept && in_item.kind) begin
      if (in_item.compartment_index < 4'(NComp)) begin
        comp[in_item.compartment_index] <= in_item.compartment_value;
      end
    end else if (state == ST_ISSUE && uop.op == OP_UPD) begin
      comp[uop.ci] <= upd_val;
    end
  end

  // arithmetic units, working registers and result
  always_ff @(posedge clk) begin
    if (accept) begin
      carb <= in_item.carb_rate;
      iir  <= in_item.infusion_rate;
    end
    if (state == ST_ISSUE && uop.op == OP_MUL) begin
      mul_a   <= op_a;
      mul_b   <= op_b;
      acc     <= '0;
      mul_cnt <= '0;
    end
    if (state == ST_MUL) begin
      acc     <= {acc[127-DigitW:0], {DigitW{1'b0}}} + 128'(pp);
      mul_b   <= {mul_b[WideW-DigitW-1:0], {DigitW{1'b0}}};
      mul_cnt <= mul_cnt + 1'b1;
    end
    if (state == ST_ISSUE && uop.op == OP_DIV) begin
      div_num <= op_a;
      div_den <= op_b[31:0];
      div_rem <= '0;
      div_quo <= '0;
      div_cnt <= '0;
    end
    if (state == ST_DIV) begin
      div_rem <= div_ge ? 32'(div_trial - {1'b0, div_den}) : div_trial[31:0];
      div_quo <= {div_quo[WideW-2:0], div_ge};
      div_num <= {div_num[WideW-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
    if (wb_en) begin
      case (uop.dst)
        DST_DVOL:  dvol  <= wb_val[31:0];
        DST_G:     g     <= wb_val;
        // brain uptake scales only below the low glucose threshold
        DST_RATIO: ratio <= (g < C_G45) ? wb_val[24:0] : C_ONE24[24:0];
        DST_TMP:   tmp   <= wb_val;
        DST_POS:   pos   <= wb_val;
        DST_NEG:   neg   <= wb_val;
        DST_XFER:  xfer  <= wb_val[55:0];
        DST_UG:    ug    <= wb_val[34:0];
        DST_SHR:   shr   <= wb_val[34:0];
        default: ;
      endcase
    end
    if (state == ST_ISSUE && uop.op == OP_OUT) begin
      out_item.glucose_mg_dl  <= (|tmp[63:24]) ? '1 : tmp[23:0];
      out_item.plasma_insulin <= comp[CI_I][39:16];
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after an item was accepted");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && mul_cnt == MulCntW'(MulDigits - 1)) |=> (state == ST_WB))
    else $error("multiply did not end after its last digit");

endmodule

`default_nettype wire

FILE: bench/glucose_insulin_model_step_tb.sv
// self-checking bench for glucose_insulin_model_step: directed and random ticks and loads
// depends on gim_pkg and the rtl top; a scoreboard class predicts each result
`timescale 1ns / 1ps

module glucose_insulin_model_step_tb;
  import gim_pkg::*;

  localparam logic [63:0] MASK40 = 64'hFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 6000000;

  class glucose_tracker;
    comp_t       comp[NComp];
    logic [63:0] regs[8];
    out_item_t   pending[$];
    int          fails;

    function new();
      foreach (comp[i]) comp[i] = '0;
      regs[REG_BODY_WEIGHT]      = RST_BODY_WEIGHT;
      regs[REG_GLUCOSE_VOLUME]   = RST_GLUCOSE_VOLUME;
      regs[REG_SENS_TRANSPORT]   = RST_SENS_TRANSPORT;
      regs[REG_SENS_DISPOSAL]    = RST_SENS_DISPOSAL;
      regs[REG_SENS_PRODUCTION]  = RST_SENS_PRODUCTION;
      regs[REG_BASAL_PRODUCTION] = RST_BASAL_PRODUCTION;
      regs[REG_BRAIN_UPTAKE]     = RST_BRAIN_UPTAKE;
      regs[REG_STEP_MINUTES]     = RST_STEP_MINUTES;
      fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] v);
      if (idx == REG_BODY_WEIGHT || idx == REG_GLUCOSE_VOLUME || idx == REG_STEP_MINUTES)
        regs[idx] = {48'd0, v[15:0]};
      else
        regs[idx] = {40'd0, v};
    endfunction

    function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> sh;
      return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function logic [63:0] at_least_one(logic [63:0] v);
      return (v == 0) ? 64'd1 : v;
    endfunction

    // glucose concentration, q.24 mmol/l, exact long division in two halves
    function logic [63:0] conc(comp_t q1);
      logic [63:0] d, a, q, r;
      d = at_least_one(regs[REG_GLUCOSE_VOLUME]) * at_least_one(regs[REG_BODY_WEIGHT]);
      a = {24'd0, q1} << 12;
      q = a / d;
      r = a % d;
      return (q << 12) + ((r << 12) / d);
    endfunction

    function comp_t advance(comp_t old, logic [63:0] pos, logic [63:0] neg);
      logic [63:0] up, down, r, o;
      up   = mul_sat(pos, regs[REG_STEP_MINUTES], 8);
      down = mul_sat(neg, regs[REG_STEP_MINUTES], 8);
      o    = {24'd0, old};
      if (up >= down) begin
        r = add_sat(o, up - down);
        return (r > MASK40) ? MASK40[39:0] : r[39:0];
      end
      return (o > down - up) ? comp_t'(o - (down - up)) : '0;
    endfunction

    function void euler_tick(logic [15:0] carb, logic [15:0] iir);
      logic [63:0] c[NComp];
      logic [63:0] pos[NComp], neg[NComp];
      logic [63:0] g, ratio, brain, renal, ug, x3c, egp, xfer, s1o, s2o, d1o, bw;
      foreach (c[i]) c[i] = {24'd0, comp[i]};
      bw    = regs[REG_BODY_WEIGHT];
      g     = conc(comp[CI_Q1]);
      ratio = (g < C_G45) ? mul_sat(g, C_R45, 24) : C_ONE24;
      brain = mul_sat(mul_sat(regs[REG_BRAIN_UPTAKE], bw, 8), ratio, 24);
      renal = (g > C_G9) ? mul_sat(g - C_G9, C_FR, 24) : 64'd0;
      ug    = mul_sat(c[CI_D2], C_RTG, 24);
      x3c   = (c[CI_X3] > C_ONE24) ? C_ONE24 : c[CI_X3];
      egp   = mul_sat(mul_sat(regs[REG_BASAL_PRODUCTION], bw, 8), C_ONE24 - x3c, 24);
      xfer  = mul_sat(c[CI_X1], c[CI_Q1], 24);
      s1o   = mul_sat(c[CI_S1], C_RTI, 24);
      s2o   = mul_sat(c[CI_S2], C_RTI, 24);
      d1o   = mul_sat(c[CI_D1], C_RTG, 24);
      pos[CI_Q1] = add_sat(add_sat(mul_sat(C_K12, c[CI_Q2], 24), ug), egp);
      neg[CI_Q1] = add_sat(add_sat(brain, xfer), renal);
      pos[CI_Q2] = xfer;
      neg[CI_Q2] = mul_sat(C_K12 + c[CI_X2], c[CI_Q2], 24);
      pos[CI_S1] = {48'd0, iir} * C_IIR;
      neg[CI_S1] = s1o;
      pos[CI_S2] = s1o;
      neg[CI_S2] = s2o;
      pos[CI_I]  = ((c[CI_S2] * C_IGAIN) / at_least_one(bw)) >> 16;
      neg[CI_I]  = mul_sat(C_KE, c[CI_I], 24);
      pos[CI_X1] = mul_sat(C_KA1, mul_sat(regs[REG_SENS_TRANSPORT], c[CI_I], 24), 24);
      neg[CI_X1] = mul_sat(C_KA1, c[CI_X1], 24);
      pos[CI_X2] = mul_sat(C_KA2, mul_sat(regs[REG_SENS_DISPOSAL], c[CI_I], 24), 24);
      neg[CI_X2] = mul_sat(C_KA2, c[CI_X2], 24);
      pos[CI_X3] = mul_sat(C_KA3, mul_sat(regs[REG_SENS_PRODUCTION], c[CI_I], 24), 24);
      neg[CI_X3] = mul_sat(C_KA3, c[CI_X3], 24);
      pos[CI_D1] = mul_sat({48'd0, carb} * C_CARB, C_AG, 24);
      neg[CI_D1] = d1o;
      pos[CI_D2] = d1o;
      neg[CI_D2] = ug;
      foreach (comp[i]) comp[i] = advance(comp[i], pos[i], neg[i]);
    endfunction

    function void note_item(in_item_t it);
      out_item_t   e;
      logic [63:0] mg;
      if (it.kind == 1'b0)
        euler_tick(it.carb_rate, it.infusion_rate);
      else if (it.compartment_index < NComp)
        comp[it.compartment_index] = it.compartment_value;
      mg = mul_sat(conc(comp[CI_Q1]), C_MGDL, 32);
      e.glucose_mg_dl  = (mg > 64'hFF_FFFF) ? 24'hFF_FFFF : mg[23:0];
      e.plasma_insulin = comp[CI_I][39:16];
      pending.push_back(e);
    endfunction

    function void check_item(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item: glucose %0d insulin %0d",
               got.glucose_mg_dl, got.plasma_insulin);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.glucose_mg_dl !== e.glucose_mg_dl) begin
        $error("glucose_mg_dl: expected %0d, actual %0d", e.glucose_mg_dl, got.glucose_mg_dl);
        fails++;
      end
      if (got.plasma_insulin !== e.plasma_insulin) begin
        $error("plasma_insulin: expected %0d, actual %0d", e.plasma_insulin,
               got.plasma_insulin);
        fails++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  glucose_tracker tracker = new();
  bit             hold_req = 1'b0;
  int unsigned    cycles = 0;

  glucose_insulin_model_step u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tracker.note_item(in_item);
    if (!rst && out_valid && out_ready) tracker.check_item(out_item);
  end

  // receiver: stall pattern changes after each random span, one long hold on request
  initial begin
    int mode;
    int span;
    bit held;
    mode = 0;
    span = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        held = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(50, 400);
      end
      span--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic offer_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic in_item_t load_item(logic [3:0] idx, logic [39:0] v);
    in_item_t it;
    it = '0;
    it.kind = 1'b1;
    it.compartment_index = idx;
    it.compartment_value = v;
    it.carb_rate = 16'($urandom);
    it.infusion_rate = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [15:0] carb, logic [15:0] iir);
    in_item_t it;
    it = '0;
    it.carb_rate = carb;
    it.infusion_rate = iir;
    it.compartment_index = 4'($urandom);
    it.compartment_value = 40'({$urandom, $urandom});
    return it;
  endfunction

  // mostly ticks; loads set random, shifted or near-range values, a few at ignored indexes
  function automatic in_item_t random_item();
    logic [39:0] v;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 3))
        0: v = 40'({$urandom, $urandom});
        1: v = {8'd0, $urandom} >> $urandom_range(0, 31);
        default: v = ({16'd0, 24'(1)} * 40'($urandom_range(0, 300)))
                     + 40'($urandom_range(0, 24'hFFFFFF));
      endcase
      return load_item(($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(0, 9)), v);
    end
    case ($urandom_range(0, 5))
      0: return tick_item(16'($urandom_range(0, 1)) * 16'hFFFF, 16'($urandom));
      1: return tick_item(16'($urandom), 16'($urandom_range(0, 1)) * 16'hFFFF);
      2: return tick_item(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 5000)));
      default: return tick_item(16'($urandom), 16'($urandom));
    endcase
  endfunction

  task automatic offer_series(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        offer_item(random_item());
        burst--;
        left--;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    tracker.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic apply_config(logic [15:0] bw, logic [15:0] vg, logic [23:0] st,
                              logic [23:0] sd, logic [23:0] sp, logic [23:0] bp,
                              logic [23:0] bu, logic [15:0] stp);
    write_reg(REG_BODY_WEIGHT, {8'd0, bw});
    write_reg(REG_GLUCOSE_VOLUME, {8'd0, vg});
    write_reg(REG_SENS_TRANSPORT, st);
    write_reg(REG_SENS_DISPOSAL, sd);
    write_reg(REG_SENS_PRODUCTION, sp);
    write_reg(REG_BASAL_PRODUCTION, bp);
    write_reg(REG_BRAIN_UPTAKE, bu);
    write_reg(REG_STEP_MINUTES, {8'd0, stp});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, low and high glucose, capped x3, ignored load index
    offer_item(tick_item(16'd0, 16'd0));
    offer_item(tick_item(16'hFFFF, 16'hFFFF));
    offer_item(load_item(CI_Q1, 40'd0));
    offer_item(load_item(CI_Q1, 40'hFF_FFFF_FFFF));
    offer_item(tick_item(16'd0, 16'd0));
    offer_item(load_item(CI_Q1, 40'd3 << 24));
    offer_item(tick_item(16'd100, 16'd1000));
    offer_item(load_item(CI_Q1, 40'd40 << 24));
    offer_item(load_item(CI_X3, 40'd2 << 24));
    offer_item(tick_item(16'd50, 16'd500));
    offer_item(load_item(CI_X3, 40'hFF_FFFF_FFFF));
    offer_item(load_item(CI_I, 40'hFF_FFFF_FFFF));
    offer_item(load_item(CI_S2, 40'hFF_FFFF_FFFF));
    offer_item(load_item(CI_X1, 40'hFF_FFFF_FFFF));
    offer_item(tick_item(16'hFFFF, 16'd0));
    offer_item(load_item(4'd10, 40'h12_3456_789A));
    offer_item(load_item(4'd15, 40'hFF_FFFF_FFFF));
    offer_item(load_item(CI_D1, 40'd60 << 24));
    offer_item(load_item(CI_D2, 40'd30 << 24));
    offer_item(load_item(CI_Q2, 40'd20 << 24));
    offer_item(tick_item(16'd0, 16'hFFFF));
    offer_item(load_item(CI_X2, 40'd0));
    offer_item(tick_item(16'd1, 16'd1));
    in_valid <= 1'b0;
    @(posedge clk);

    offer_series(120);
    hold_req = 1'b1;
    offer_series(12);
    wait_drained();
    offer_series(150);
    wait_drained();

    apply_config(RST_BODY_WEIGHT, RST_GLUCOSE_VOLUME, RST_SENS_TRANSPORT, RST_SENS_DISPOSAL,
                 RST_SENS_PRODUCTION, RST_BASAL_PRODUCTION, RST_BRAIN_UPTAKE,
                 RST_STEP_MINUTES);
    offer_series(200);
    wait_drained();

    // zero weight and volume fall back to one lsb as divisors
    apply_config(16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 16'd1);
    offer_series(200);
    wait_drained();

    apply_config(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                 24'hFF_FFFF, 16'hFFFF);
    offer_series(200);
    wait_drained();

    apply_config(16'd256, 16'd1, 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 24'($urandom), 16'hFFFF);
    offer_series(200);
    wait_drained();

    apply_config(16'($urandom_range(256, 65535)), 16'($urandom_range(1, 65535)),
                 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 16'($urandom_range(1, 2048)));
    offer_series(400);
    wait_drained();

    repeat (600) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gim_pkg.sv
hw/rtl/glucose_insulin_model_step.sv
bench/glucose_insulin_model_step_tb.sv
